// ===== hdl/biq_pkg.sv =====
package biq_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int COEF_W        = 32;
  localparam int DELAY_W       = 48;
  localparam int COEF_FRAC_DEF = 29;
  localparam int CFG_IDX_W     = 3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       restart;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       clipped;
  } out_beat_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } coef_reg_t;

  typedef enum logic [2:0] {
    MUL_B0X,
    MUL_B1X,
    MUL_B2X,
    MUL_A1Y,
    MUL_A2Y
  } mul_src_t;

  typedef enum logic [2:0] {
    ADD_PROD_D1,
    ADD_PROD_D2,
    ADD_PROD_ZERO,
    ADD_ACC_HALF,
    ADD_ACC_SUB_PROD
  } add_op_t;

  typedef struct packed {
    mul_src_t mul_src;
    logic     mul_en;
    add_op_t  add_op;
    logic     acc_en;
    logic     y_en;
    logic     d1_en;
    logic     d2_en;
    logic     clr_delay;
    logic     x_en;
    logic     out_load;
  } ctl_t;

endpackage

// ===== hdl/biquad_iir_section_core.sv =====
// Biquad IIR section, transposed direct form II, fixed point.
// Input channel in_valid/in_ready carries one beat: a signed sample and a
// restart bit that clears both delay registers before that sample.
// Output channel out_valid/out_ready carries the rounded, saturated sample
// and a clipped flag.
// Config channel cfg_valid/cfg_ready writes coefficient cfg_index
// (0 b0, 1 b1, 2 b2, 3 a1, 4 a2, signed Q2.29 by default); other indexes
// are dropped. cfg_ready is always high; write only while the filter is idle.
// One sample takes the accept cycle plus six steps in which a
// single 32x16 multiplier and a single add/subtract unit form the five
// products and three sums in turn. in_ready is low during those steps, so
// a new beat is taken only once the block is through with the last one.
// The result and out_valid are registered in the last step. The
// output register frees the datapath: a new beat is taken while a result
// still waits. If the receiver stalls, the next sample stops at its last
// step until the output register is taken.
// Synchronous reset clears the delays, sets b0 to 1.0 and the rest to 0.
module biquad_iir_section_core #(
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  biq_pkg::in_beat_t               in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output biq_pkg::out_beat_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [biq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]      cfg_data
);

  localparam int SW = biq_pkg::SAMPLE_W;
  localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

  biq_pkg::ctl_t                  ctl;
  logic signed [biq_pkg::COEF_W-1:0] coef;
  logic signed [SW-1:0]            y;
  logic                            clip;

  assign cfg_ready = 1'b1;

  biq_coef_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_coef_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .mul_src  (ctl.mul_src),
    .coef     (coef)
  );

  biq_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .restart  (in_data.restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .ctl      (ctl)
  );

  biq_datapath #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .in_sample(in_data.sample_in),
    .coef     (coef),
    .y        (y),
    .clip     (clip)
  );

  // output register
  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_data.sample_out <= y;
      out_data.clipped    <= clip;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sequencer ready again straight after an input beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!out_valid || out_ready))
    else $error("pending output beat overwritten");

  a_clip_at_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.clipped |->
      (out_data.sample_out == SAT_MAX || out_data.sample_out == SAT_MIN))
    else $error("clipped flag set on an unsaturated sample");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("output beat without a preceding computation");

endmodule

// ===== hdl/biq_coef_regs.sv =====
module biq_coef_regs #(
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [biq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [biq_pkg::COEF_W-1:0]          cfg_data,
  input  biq_pkg::mul_src_t                   mul_src,
  output logic signed [biq_pkg::COEF_W-1:0]   coef
);

  localparam int CW = biq_pkg::COEF_W;
  localparam logic signed [CW-1:0] ONE = CW'(64'd1 << COEF_FRAC_BITS);

  logic signed [CW-1:0] b0, b1, b2, a1, a2;

  always_ff @(posedge clk) begin
    if (rst) begin
      b0 <= ONE;
      b1 <= '0;
      b2 <= '0;
      a1 <= '0;
      a2 <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        biq_pkg::REG_B0: b0 <= cfg_data;
        biq_pkg::REG_B1: b1 <= cfg_data;
        biq_pkg::REG_B2: b2 <= cfg_data;
        biq_pkg::REG_A1: a1 <= cfg_data;
        biq_pkg::REG_A2: a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (mul_src)
      biq_pkg::MUL_B0X: coef = b0;
      biq_pkg::MUL_B1X: coef = b1;
      biq_pkg::MUL_B2X: coef = b2;
      biq_pkg::MUL_A1Y: coef = a1;
      biq_pkg::MUL_A2Y: coef = a2;
      default:          coef = b0;
    endcase
  end

endmodule

// ===== hdl/biq_datapath.sv =====
module biq_datapath #(
  parameter int COEF_FRAC_BITS = biq_pkg::COEF_FRAC_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  biq_pkg::ctl_t                        ctl,
  input  logic signed [biq_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic signed [biq_pkg::COEF_W-1:0]    coef,
  output logic signed [biq_pkg::SAMPLE_W-1:0]  y,
  output logic                                 clip
);

  localparam int SW     = biq_pkg::SAMPLE_W;
  localparam int DW     = biq_pkg::DELAY_W;
  localparam int PROD_W = biq_pkg::COEF_W + SW;
  localparam int ACC_W  = ((PROD_W > DW) ? PROD_W : DW) + 2;

  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] DMAX = {{(ACC_W-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DMIN = {{(ACC_W-DW+1){1'b1}}, {(DW-1){1'b0}}};

  logic signed [SW-1:0]     x;
  logic signed [SW-1:0]     mul_b;
  logic signed [PROD_W-1:0] prod, prod_next;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  opa, opb, sum, shifted;
  logic                     sub;
  logic signed [SW-1:0]     y_next;
  logic                     clip_next;
  logic signed [DW-1:0]     d1, d2, d_sat;

  // shared multiplier
  always_comb begin
    case (ctl.mul_src) inside
      biq_pkg::MUL_A1Y, biq_pkg::MUL_A2Y: mul_b = y;
      default: mul_b = ctl.x_en ? in_sample : x;
    endcase
  end

  assign prod_next = PROD_W'(coef) * PROD_W'(mul_b);

  // shared add/subtract unit
  always_comb begin
    opa = acc;
    opb = '0;
    sub = 1'b0;
    case (ctl.add_op)
      biq_pkg::ADD_PROD_D1: begin
        opa = ACC_W'(prod);
        opb = ACC_W'(d1);
      end
      biq_pkg::ADD_PROD_D2: begin
        opa = ACC_W'(prod);
        opb = ACC_W'(d2);
      end
      biq_pkg::ADD_PROD_ZERO: begin
        opa = ACC_W'(prod);
      end
      biq_pkg::ADD_ACC_HALF: begin
        opb = HALF;
      end
      biq_pkg::ADD_ACC_SUB_PROD: begin
        opb = ACC_W'(prod);
        sub = 1'b1;
      end
      default: ;
    endcase
    sum = sub ? (opa - opb) : (opa + opb);
  end

  // round and saturate the output sample
  always_comb begin
    shifted   = sum >>> COEF_FRAC_BITS;
    clip_next = 1'b0;
    if (shifted > SMAX) begin
      y_next    = SMAX[SW-1:0];
      clip_next = 1'b1;
    end else if (shifted < SMIN) begin
      y_next    = SMIN[SW-1:0];
      clip_next = 1'b1;
    end else begin
      y_next = shifted[SW-1:0];
    end
  end

  // delay saturation, silent
  always_comb begin
    if (sum > DMAX) begin
      d_sat = DMAX[DW-1:0];
    end else if (sum < DMIN) begin
      d_sat = DMIN[DW-1:0];
    end else begin
      d_sat = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d1 <= '0;
      d2 <= '0;
    end else begin
      if (ctl.clr_delay) begin
        d1 <= '0;
        d2 <= '0;
      end
      if (ctl.d1_en) begin
        d1 <= d_sat;
      end
      if (ctl.d2_en) begin
        d2 <= d_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.x_en) begin
      x <= in_sample;
    end
    if (ctl.mul_en) begin
      prod <= prod_next;
    end
    if (ctl.acc_en) begin
      acc <= sum;
    end
    if (ctl.y_en) begin
      y    <= y_next;
      clip <= clip_next;
    end
  end

endmodule

// ===== hdl/biq_seq.sv =====
module biq_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          restart,
  output logic          out_valid,
  input  logic          out_ready,
  output biq_pkg::ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC1,
    S_RND,
    S_FB1,
    S_D1W,
    S_FB2,
    S_D2W
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    ctl        = '0;
    ctl.mul_src = biq_pkg::MUL_B0X;
    ctl.add_op  = biq_pkg::ADD_PROD_ZERO;
    state_next  = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.x_en      = 1'b1;
          ctl.clr_delay = restart;
          ctl.mul_src   = biq_pkg::MUL_B0X;
          ctl.mul_en    = 1'b1;
          state_next    = S_ACC1;
        end
      end
      S_ACC1: begin
        ctl.add_op  = biq_pkg::ADD_PROD_D1;
        ctl.acc_en  = 1'b1;
        ctl.mul_src = biq_pkg::MUL_B1X;
        ctl.mul_en  = 1'b1;
        state_next  = S_RND;
      end
      S_RND: begin
        ctl.add_op = biq_pkg::ADD_ACC_HALF;
        ctl.y_en   = 1'b1;
        state_next = S_FB1;
      end
      S_FB1: begin
        ctl.add_op  = biq_pkg::ADD_PROD_D2;
        ctl.acc_en  = 1'b1;
        ctl.mul_src = biq_pkg::MUL_A1Y;
        ctl.mul_en  = 1'b1;
        state_next  = S_D1W;
      end
      S_D1W: begin
        ctl.add_op  = biq_pkg::ADD_ACC_SUB_PROD;
        ctl.d1_en   = 1'b1;
        ctl.mul_src = biq_pkg::MUL_B2X;
        ctl.mul_en  = 1'b1;
        state_next  = S_FB2;
      end
      S_FB2: begin
        ctl.add_op  = biq_pkg::ADD_PROD_ZERO;
        ctl.acc_en  = 1'b1;
        ctl.mul_src = biq_pkg::MUL_A2Y;
        ctl.mul_en  = 1'b1;
        state_next  = S_D2W;
      end
      S_D2W: begin
        ctl.add_op = biq_pkg::ADD_ACC_SUB_PROD;
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          ctl.d2_en    = 1'b1;
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= ctl.out_load || (out_valid && !out_ready);
    end
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int     FRAC        = biq_pkg::COEF_FRAC_DEF;
  localparam longint UNITY       = longint'(1) << FRAC;
  localparam longint TAP_MAX     = 64'sd2147483647;
  localparam longint TAP_MIN     = -64'sd2147483648;
  localparam longint POLE_LIM    = 64'sd483183820;
  localparam int     CYCLE_LIMIT = 400000;
  localparam int     SETTLE      = 20;

  typedef struct {
    biq_pkg::in_beat_t beat;
    bit                hold;
  } pend_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  biq_pkg::in_beat_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  biq_pkg::out_beat_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [biq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [biq_pkg::COEF_W-1:0]    cfg_data  = '0;

  pend_beat_t         send_q[$];
  pend_beat_t         next_beat;
  biq_pkg::out_beat_t filtered_q[$];
  biq_pkg::out_beat_t seen;
  biq_pkg::out_beat_t want;

  longint taps [5];
  longint delay_1;
  longint delay_2;

  bit in_took  = 1'b0;
  bit out_took = 1'b0;
  int send_wait = 0;
  int recv_wait = 0;
  int send_gap_max = 0;
  int recv_stall_max = 0;

  int cycles = 0;
  int n_checked = 0;
  int n_clipped = 0;
  int n_restarts = 0;
  int n_writes = 0;
  int n_settings = 0;
  int n_errors = 0;

  biquad_iir_section_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_to(input longint v, input int w, output bit hit);
    longint hi;
    longint lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    hit = 1'b0;
    clamp_to = v;
    if (v > hi) begin
      hit = 1'b1;
      clamp_to = hi;
    end else if (v < lo) begin
      hit = 1'b1;
      clamp_to = lo;
    end
  endfunction

  // transposed direct form ii, one sample through the section
  function automatic biq_pkg::out_beat_t filter_sample(input biq_pkg::in_beat_t b);
    biq_pkg::out_beat_t r;
    longint    x;
    longint    acc;
    longint    y;
    longint    n1;
    longint    n2;
    bit        hit;
    bit        ignore;
    x = $signed(b.sample_in);
    if (b.restart) begin
      delay_1 = 0;
      delay_2 = 0;
    end
    acc = taps[biq_pkg::REG_B0] * x + delay_1;
    y   = (acc + (longint'(1) << (FRAC - 1))) >>> FRAC;
    y   = clamp_to(y, biq_pkg::SAMPLE_W, hit);
    n1  = taps[biq_pkg::REG_B1] * x - taps[biq_pkg::REG_A1] * y + delay_2;
    n2  = taps[biq_pkg::REG_B2] * x - taps[biq_pkg::REG_A2] * y;
    delay_1 = clamp_to(n1, biq_pkg::DELAY_W, ignore);
    delay_2 = clamp_to(n2, biq_pkg::DELAY_W, ignore);
    r.sample_out = y[biq_pkg::SAMPLE_W-1:0];
    r.clipped    = hit;
    return r;
  endfunction

  always @(posedge clk) begin
    in_took  <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, filtered_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
    if (rst) begin
      taps[biq_pkg::REG_B0] = UNITY;
      taps[biq_pkg::REG_B1] = 0;
      taps[biq_pkg::REG_B2] = 0;
      taps[biq_pkg::REG_A1] = 0;
      taps[biq_pkg::REG_A2] = 0;
      delay_1 = 0;
      delay_2 = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        n_writes++;
        if (cfg_index <= biq_pkg::REG_A2)
          taps[cfg_index] = $signed(cfg_data);
      end
      if (in_valid && in_ready) begin
        if (in_data.restart)
          n_restarts++;
        filtered_q.push_back(filter_sample(in_data));
      end
      if (out_valid && out_ready) begin
        seen = out_data;
        if (filtered_q.size() == 0) begin
          n_errors++;
          $display("%t: unexpected output beat sample_out=%0d clipped=%0b",
                   $time, seen.sample_out, seen.clipped);
        end else begin
          want = filtered_q.pop_front();
          n_checked++;
          if (want.clipped)
            n_clipped++;
          if (seen.sample_out !== want.sample_out) begin
            n_errors++;
            $display("%t: sample_out expected %0d got %0d",
                     $time, want.sample_out, seen.sample_out);
          end
          if (seen.clipped !== want.clipped) begin
            n_errors++;
            $display("%t: clipped expected %0b got %0b", $time, want.clipped, seen.clipped);
          end
        end
      end
    end
  end

  // input beat driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (send_wait > 0) begin
        send_wait--;
        in_valid <= 1'b0;
      end else if (send_q.size() != 0 && !(send_q[0].hold && filtered_q.size() != 0)) begin
        next_beat = send_q.pop_front();
        in_data  <= next_beat.beat;
        in_valid <= 1'b1;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    if (out_took)
      recv_wait = $urandom_range(0, recv_stall_max);
    if (rst) begin
      out_ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic biq_pkg::in_beat_t make_beat(input int s, input bit r);
    biq_pkg::in_beat_t b;
    b.sample_in = s[biq_pkg::SAMPLE_W-1:0];
    b.restart   = r;
    return b;
  endfunction

  function automatic biq_pkg::in_beat_t rand_beat();
    biq_pkg::in_beat_t b;
    case ($urandom_range(0, 15))
      0: b.sample_in = 16'h7fff;
      1: b.sample_in = 16'h8000;
      2, 3, 4: b.sample_in = biq_pkg::SAMPLE_W'($urandom_range(0, 512) - 256);
      default: b.sample_in = biq_pkg::SAMPLE_W'($urandom);
    endcase
    b.restart = ($urandom_range(0, 39) == 0);
    return b;
  endfunction

  function automatic longint rand_half();
    return longint'($urandom_range(0, 1 << (FRAC))) - (longint'(1) << (FRAC - 1));
  endfunction

  task automatic queue_beat(input int s, input bit r);
    pend_beat_t p;
    p.beat = make_beat(s, r);
    p.hold = 1'b0;
    send_q.push_back(p);
  endtask

  task automatic queue_random(input int n, input int hold_every);
    pend_beat_t p;
    for (int i = 0; i < n; i++) begin
      p.beat = rand_beat();
      p.hold = (hold_every != 0) && (i % hold_every == hold_every - 1);
      send_q.push_back(p);
    end
  endtask

  task automatic write_coef(input logic [biq_pkg::CFG_IDX_W-1:0] idx, input longint val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[biq_pkg::COEF_W-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_taps(input longint b0, input longint b1, input longint b2,
                            input longint a1, input longint a2);
    write_coef(biq_pkg::REG_B0, b0);
    write_coef(biq_pkg::REG_B1, b1);
    write_coef(biq_pkg::REG_B2, b2);
    write_coef(biq_pkg::REG_A1, a1);
    write_coef(biq_pkg::REG_A2, a2);
    n_settings++;
  endtask

  // poles kept inside the stability triangle
  task automatic write_stable_taps();
    longint a1;
    longint a2;
    longint lim;
    a2  = longint'($urandom_range(0, 32'(2 * POLE_LIM))) - POLE_LIM;
    lim = ((UNITY + a2) * 9) / 10;
    a1  = longint'($urandom_range(0, 32'(2 * lim))) - lim;
    write_taps(rand_half(), rand_half(), rand_half(), a1, a2);
  endtask

  task automatic settle();
    do begin
      @(negedge clk);
      #1;
    end while (send_q.size() != 0 || in_valid || filtered_q.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    n_settings = 1;

    // reset taps pass the sample straight through
    send_gap_max   = 3;
    recv_stall_max = 3;
    queue_beat(0, 1'b0);
    queue_beat(32767, 1'b0);
    queue_beat(-32768, 1'b0);
    queue_beat(1, 1'b0);
    queue_beat(-1, 1'b0);
    queue_beat(21845, 1'b0);
    queue_beat(-21846, 1'b0);
    queue_beat(100, 1'b1);
    settle();

    // gain near 4 drives the output into both rails
    write_taps(TAP_MAX, 0, 0, 0, 0);
    queue_beat(32767, 1'b0);
    queue_beat(-32768, 1'b0);
    queue_beat(8191, 1'b0);
    queue_beat(8192, 1'b0);
    queue_beat(-8192, 1'b0);
    queue_beat(-8193, 1'b0);
    settle();

    // extreme feedback saturates the delay line
    write_taps(TAP_MAX, TAP_MAX, TAP_MAX, TAP_MIN, TAP_MIN);
    queue_beat(32767, 1'b0);
    queue_beat(32767, 1'b0);
    queue_beat(32767, 1'b0);
    queue_beat(-32768, 1'b0);
    queue_beat(-32768, 1'b0);
    queue_beat(-32768, 1'b0);
    queue_beat(32767, 1'b1);
    settle();

    // half gain for rounding ties, then writes to unused indexes
    write_taps(UNITY / 2, 0, 0, 0, 0);
    for (int i = int'(biq_pkg::REG_A2) + 1; i < (1 << biq_pkg::CFG_IDX_W); i++)
      write_coef(i[biq_pkg::CFG_IDX_W-1:0], longint'($urandom));
    queue_beat(1, 1'b0);
    queue_beat(-1, 1'b0);
    queue_beat(3, 1'b0);
    queue_beat(-3, 1'b0);
    settle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin
          write_taps(UNITY, 0, 0, 0, 0);
          send_gap_max = 8; recv_stall_max = 8;
        end
        1: begin
          write_taps(64'sd36238787, 64'sd72477574, 64'sd36238787,
                     -64'sd613637200, 64'sd221620313);
          send_gap_max = 0; recv_stall_max = 0;
        end
        2: begin
          write_stable_taps();
          send_gap_max = 8; recv_stall_max = 4;
        end
        3: begin
          write_taps(TAP_MAX, TAP_MAX, TAP_MAX, TAP_MAX, TAP_MAX);
          send_gap_max = 4; recv_stall_max = 0;
        end
        4: begin
          write_taps(TAP_MIN, TAP_MIN, TAP_MIN, TAP_MIN, TAP_MIN);
          send_gap_max = 0; recv_stall_max = 8;
        end
        5: begin
          write_taps(longint'($urandom), longint'($urandom), longint'($urandom),
                     longint'($urandom), longint'($urandom));
          send_gap_max = 8; recv_stall_max = 0;
        end
        6: begin
          write_stable_taps();
          send_gap_max = 8; recv_stall_max = 8;
        end
        default: begin
          write_taps(UNITY, -64'sd858993459, UNITY, -64'sd816043786, 64'sd484525998);
          send_gap_max = 2; recv_stall_max = 2;
        end
      endcase
      queue_random(128, (p == 2 || p == 6) ? 40 : 0);
      settle();
    end

    $display("checked %0d output beats over %0d coefficient sets (%0d register writes)",
             n_checked, n_settings, n_writes);
    $display("%0d beats saturated, %0d restarts, %0d mismatches",
             n_clipped, n_restarts, n_errors);
    if (n_errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
